// ===== rtl/pccd_pkg.sv =====
// Package for the packed code codebook dequantizer.
// Holds operation codes, register indexes and the single to half precision conversion.
// No dependencies.
package pccd_pkg;

   typedef enum logic [1:0] {
      OP_WRITE_ENTRY = 2'd0,
      OP_START_TILE  = 2'd1,
      OP_DATA_BYTE   = 2'd2,
      OP_UNUSED      = 2'd3
   } op_type;

   localparam logic CSR_BIT_WIDTH = 1'b0;
   localparam logic CSR_CODE_MASK = 1'b1;

   // Convert a single-precision bit pattern to half precision, round to nearest even.
   function automatic logic [15:0] to_half(input logic [31:0] f);
      logic [15:0] sign;
      logic [7:0]  ex;
      logic [22:0] man;
      logic signed [9:0] e;
      logic [23:0] m;
      logic [4:0]  sh;
      logic [23:0] rem;
      logic [23:0] halfway;
      logic [15:0] h;
      logic [12:0] lrem;
      sign = {f[31], 15'd0};
      ex = f[30:23];
      man = f[22:0];
      e = $signed({2'b00, ex}) - 10'sd112;
      m = {1'b1, man};
      sh = 5'd0;
      rem = '0;
      halfway = '0;
      lrem = man[12:0];
      h = '0;
      if (ex == 8'hFF) begin
         if (man != 23'd0) h = sign | 16'h7E00 | {6'd0, man[22:13]};
         else h = sign | 16'h7C00;
      end else if (e >= 10'sd31) begin
         h = sign | 16'h7C00;
      end else if (e <= 10'sd0) begin
         if (e < -10'sd10) begin
            h = sign;
         end else begin
            sh = 5'(10'sd14 - e);
            h = 16'(m >> sh);
            rem = m & ((24'd1 << sh) - 24'd1);
            halfway = 24'd1 << (sh - 5'd1);
            if (rem > halfway || (rem == halfway && h[0])) h = h + 16'd1;
            h = sign | h;
         end
      end else begin
         h = {1'b0, e[4:0], man[22:13]};
         if (lrem > 13'h1000 || (lrem == 13'h1000 && h[0])) h = h + 16'd1;
         h = sign | h;
      end
      return h;
   endfunction

endpackage

// ===== rtl/pccd_unpack.sv =====
// Bit unpacker: takes data bytes and emits one masked code per cycle while code_ready holds.
// Depends on pccd_pkg.
module pccd_unpack #(
   parameter int TileW = 19
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start_valid,
   input  logic [2:0]       start_shift,
   input  logic [TileW-1:0] start_codes,
   input  logic             byte_valid,
   input  logic [7:0]       byte_data,
   output logic             byte_ready,
   input  logic [3:0]       width_cfg,
   input  logic [7:0]       mask_cfg,
   output logic             code_valid,
   input  logic             code_ready,
   output logic [7:0]       code_value,
   output logic             code_last_item,
   output logic             code_last_tile
);
   import pccd_pkg::*;

   logic [14:0]      buf_ff, buf_in;
   logic [3:0]       held_ff, held_in;
   logic [2:0]       skip_ff, skip_in;
   logic [TileW-1:0] left_ff, left_in;
   logic             busy_ff, busy_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [3:0]       bw;
   logic [14:0]      sh_buf;
   logic [3:0]       rest;
   logic [TileW-1:0] left_dec;
   logic             fire;

   // Clamp the code width to 1..8.
   always_comb begin
      bw = width_cfg;
      if (bw == 4'd0) bw = 4'd1;
      if (bw > 4'd8) bw = 4'd8;
   end

   // Emit while enough bits are held; a byte is taken when idle or as the
   // last code of the previous byte leaves. At most eight codes per byte.
   assign code_valid     = busy_ff;
   assign fire           = busy_ff && code_ready;
   assign code_value     = buf_ff[7:0] & 8'((16'd1 << bw) - 16'd1) & mask_cfg;
   assign sh_buf         = buf_ff >> bw;
   assign rest           = held_ff - bw;
   assign left_dec       = left_ff - TileW'(1);
   assign code_last_tile = left_dec == '0;
   assign code_last_item = code_last_tile || rest < bw || cnt_ff == 3'd7;
   assign byte_ready     = !busy_ff || (fire && code_last_item);

   always_comb begin
      buf_in = buf_ff; held_in = held_ff; skip_in = skip_ff;
      left_in = left_ff; busy_in = busy_ff; cnt_in = cnt_ff;
      if (fire) begin
         buf_in = sh_buf; held_in = rest; left_in = left_dec;
         busy_in = 1'b0; cnt_in = cnt_ff + 3'd1;
         if (code_last_tile) begin
            buf_in = '0; held_in = '0;
         end
      end
      if (start_valid) begin
         left_in = start_codes; skip_in = start_shift;
         buf_in = '0; held_in = '0; busy_in = 1'b0; cnt_in = '0;
      end else if (byte_valid && byte_ready && left_in != '0) begin
         buf_in = buf_in | 15'(({7'd0, byte_data} >> skip_ff) << held_in);
         held_in = held_in + 4'd8 - {1'b0, skip_ff};
         skip_in = '0;
         cnt_in = '0;
         busy_in = (held_in >= bw);
      end
      if (fire && !code_last_item && !start_valid) busy_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0; held_ff <= '0; skip_ff <= '0; left_ff <= '0; busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         buf_ff <= buf_in; held_ff <= held_in; skip_ff <= skip_in;
         left_ff <= left_in; busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== rtl/pccd_codebook.sv =====
// Codebook memory of half-precision pairs with registered read.
// Depends on pccd_pkg.
module pccd_codebook #(
   parameter int Depth = 256
) (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [7:0]  wr_index,
   input  logic [31:0] wr_first,
   input  logic [31:0] wr_second,
   input  logic        rd_en,
   input  logic [7:0]  rd_index,
   output logic [31:0] rd_data
);
   import pccd_pkg::*;

   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   logic [31:0] mem [Depth];

   // Write converts both values; out-of-range indexes are dropped.
   always_ff @(posedge clock) begin
      if (wr_en && 32'(wr_index) < Depth)
         mem[wr_index[AW-1:0]] <= {to_half(wr_first), to_half(wr_second)};
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (32'(rd_index) < Depth) rd_data <= mem[rd_index[AW-1:0]];
         else rd_data <= '0;
      end
   end
endmodule

// ===== rtl/packed_code_codebook_dequantizer.sv =====
// Packed code codebook dequantizer, top level.
// A code passes the unpack register, then the lookup register, after its byte is accepted.
// Throughput: one code per cycle while the output is not stalled; a byte yielding k codes
// occupies the unpacker until its last code leaves. Every item waits until the last code of
// the previous byte has left the unpacker. Synchronous active-high reset clears the unpacker
// state and sets the config to its defaults; the codebook is undefined until written.
module packed_code_codebook_dequantizer #(
   parameter int CODEBOOK_DEPTH = 256,
   parameter int MAX_TILE_CODES = 262144
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_code_byte,
   input  logic [7:0]  req_entry_index,
   input  logic [31:0] req_entry_first,
   input  logic [31:0] req_entry_second,
   input  logic [2:0]  req_start_shift,
   input  logic [18:0] req_tile_codes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_code_value,
   output logic [15:0] rsp_first_half,
   output logic [15:0] rsp_second_half,
   output logic        rsp_last_of_item,
   output logic        rsp_last_of_tile,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   import pccd_pkg::*;

   localparam int TileW = $clog2(MAX_TILE_CODES + 1);

   logic [3:0]  bw_ff;
   logic [7:0]  mask_ff;
   logic        in_fire, is_data, is_start, is_write;
   logic        byte_ready;
   logic        cv, cready, c_li, c_lt;
   logic [7:0]  cval;
   logic [TileW-1:0] tiles;
   logic        s_valid_ff;
   logic [7:0]  s_code_ff;
   logic        s_li_ff, s_lt_ff;
   logic [31:0] rd_data;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff <= 4'd8; mask_ff <= 8'hFF;
      end else if (csr_valid) begin
         if (csr_index == CSR_BIT_WIDTH) bw_ff <= csr_data[3:0];
         else mask_ff <= csr_data;
      end
   end

   // Items of every kind keep order behind the codes of the previous byte.
   assign is_data  = req_operation == OP_DATA_BYTE;
   assign is_start = req_operation == OP_START_TILE;
   assign is_write = req_operation == OP_WRITE_ENTRY;
   assign req_ready = byte_ready;
   assign in_fire   = req_valid && req_ready;
   assign tiles = (32'(req_tile_codes) > MAX_TILE_CODES) ? TileW'(MAX_TILE_CODES)
                                                        : TileW'(req_tile_codes);

   pccd_unpack #(.TileW(TileW)) u_unpack (
      .clock, .reset,
      .start_valid(in_fire && is_start), .start_shift(req_start_shift),
      .start_codes(tiles),
      .byte_valid(req_valid && is_data), .byte_data(req_code_byte),
      .byte_ready(byte_ready),
      .width_cfg(bw_ff), .mask_cfg(mask_ff),
      .code_valid(cv), .code_ready(cready), .code_value(cval),
      .code_last_item(c_li), .code_last_tile(c_lt)
   );

   // Lookup stage: moves when the output slot is empty or being drained.
   assign cready = !s_valid_ff || rsp_ready;

   pccd_codebook #(.Depth(CODEBOOK_DEPTH)) u_book (
      .clock, .wr_en(in_fire && is_write), .wr_index(req_entry_index),
      .wr_first(req_entry_first), .wr_second(req_entry_second),
      .rd_en(cv && cready), .rd_index(cval), .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) s_valid_ff <= 1'b0;
      else if (cready) s_valid_ff <= cv;
   end
   always_ff @(posedge clock) begin
      if (cv && cready) begin
         s_code_ff <= cval; s_li_ff <= c_li; s_lt_ff <= c_lt;
      end
   end

   assign rsp_valid        = s_valid_ff;
   assign rsp_code_value   = s_code_ff;
   assign rsp_first_half   = rd_data[31:16];
   assign rsp_second_half  = rd_data[15:0];
   assign rsp_last_of_item = s_li_ff;
   assign rsp_last_of_tile = s_lt_ff;
endmodule

// ===== rtl/pccd_checker.sv =====
// Port-level checks for the packed code codebook dequantizer.
// Depends on the top level's ports only; bound below.
module pccd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_code_value,
   input logic       rsp_last_of_item,
   input logic       rsp_last_of_tile
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_value))
      else $error("result dropped while stalled");
   a_tile_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_tile |-> rsp_last_of_item)
      else $error("tile end without item end");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");
endmodule

bind packed_code_codebook_dequantizer pccd_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_code_value,
   .rsp_last_of_item, .rsp_last_of_tile
);

// ===== dv/tb_packed_code_codebook_dequantizer.sv =====
// Self-checking testbench for the packed code codebook dequantizer.
// Predicts every code transfer from the codebook, unpacker state and registers.
// Depends on pccd_pkg and the packed_code_codebook_dequantizer RTL.
`timescale 1ns / 1ps

module tb_packed_code_codebook_dequantizer;
   import pccd_pkg::*;

   typedef struct packed {
      logic [7:0]  code;
      logic [15:0] first_h;
      logic [15:0] second_h;
      logic        item_end;
      logic        tile_end;
   } code_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_UNUSED;
   logic [7:0]  req_code_byte = '0;
   logic [7:0]  req_entry_index = '0;
   logic [31:0] req_entry_first = '0;
   logic [31:0] req_entry_second = '0;
   logic [2:0]  req_start_shift = '0;
   logic [18:0] req_tile_codes = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_code_value;
   logic [15:0] rsp_first_half;
   logic [15:0] rsp_second_half;
   logic        rsp_last_of_item;
   logic        rsp_last_of_tile;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_BIT_WIDTH;
   logic [7:0]  csr_data = '0;

   // Predictor state.
   logic [31:0] book [256];
   logic [14:0] held_bits;
   int unsigned held_count;
   int unsigned skip_count;
   int unsigned codes_pending;
   int unsigned width_reg;
   logic [7:0]  mask_reg;
   code_rec_type expected_codes [$];
   int          errors = 0;
   int          hold_cycles = 0;

   packed_code_codebook_dequantizer u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Single to half precision, round to nearest even.
   function automatic logic [15:0] half_of(logic [31:0] f);
      logic [15:0] sgn;
      int          ex;
      logic [23:0] m;
      logic [31:0] h, rem, hw;
      int          sh;
      sgn = {f[31], 15'd0};
      ex = int'(f[30:23]) - 112;
      m = {1'b1, f[22:0]};
      if (f[30:23] == 8'hFF)
         return (f[22:0] != 0) ? (sgn | 16'h7E00 | f[22:13]) : (sgn | 16'h7C00);
      if (ex >= 31) return sgn | 16'h7C00;
      if (ex <= 0) begin
         if (ex < -10) return sgn;
         sh = 14 - ex;
         h = m >> sh;
         rem = m & ((32'd1 << sh) - 1);
         hw = 32'd1 << (sh - 1);
         if (rem > hw || (rem == hw && h[0])) h++;
         return sgn | h[15:0];
      end
      h = (ex << 10) | f[22:13];
      rem = f[12:0];
      if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h++;
      return sgn | h[15:0];
   endfunction

   // Update the predictor for one accepted item.
   task automatic predict_item(logic [1:0] op, logic [7:0] byte_in, logic [7:0] idx,
                               logic [31:0] fa, logic [31:0] fb, logic [2:0] shift,
                               logic [18:0] count);
      int unsigned bw;
      int          n;
      logic [7:0]  c;
      code_rec_type r;
      bw = (width_reg == 0) ? 1 : (width_reg > 8) ? 8 : width_reg;
      n = 0;
      case (op)
         OP_WRITE_ENTRY: begin
            book[idx] = {half_of(fa), half_of(fb)};
         end
         OP_START_TILE: begin
            codes_pending = (count > 262144) ? 262144 : count;
            skip_count = shift;
            held_bits = '0;
            held_count = 0;
         end
         OP_DATA_BYTE: begin
            if (codes_pending != 0) begin
               held_bits = held_bits | ((15'(byte_in) >> skip_count) << held_count);
               held_count += 8 - skip_count;
               skip_count = 0;
               while (held_count >= bw && codes_pending > 0 && n < 8) begin
                  c = 8'(held_bits & ((15'd1 << bw) - 1)) & mask_reg;
                  held_bits = held_bits >> bw;
                  held_count -= bw;
                  codes_pending--;
                  r.code = c;
                  r.first_h = book[c][31:16];
                  r.second_h = book[c][15:0];
                  r.item_end = 1'b0;
                  r.tile_end = (codes_pending == 0);
                  expected_codes.push_back(r);
                  n++;
               end
               if (codes_pending == 0) begin
                  held_bits = '0;
                  held_count = 0;
               end
               if (n > 0) expected_codes[$].item_end = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   // Send one item after a random gap and wait for its transfer.
   task automatic send_item(logic [1:0] op, logic [7:0] byte_in, logic [7:0] idx,
                            logic [31:0] fa, logic [31:0] fb, logic [2:0] shift,
                            logic [18:0] count);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_code_byte <= byte_in;
      req_entry_index <= idx;
      req_entry_first <= fa;
      req_entry_second <= fb;
      req_start_shift <= shift;
      req_tile_codes <= count;
      do @(posedge clock); while (!req_ready);
      predict_item(op, byte_in, idx, fa, fb, shift, count);
   endtask

   task automatic send_byte(logic [7:0] b);
      send_item(OP_DATA_BYTE, b, 8'($urandom), $urandom, $urandom, 3'($urandom),
                19'($urandom));
   endtask

   task automatic send_start(logic [2:0] shift, logic [18:0] count);
      send_item(OP_START_TILE, 8'($urandom), 8'($urandom), $urandom, $urandom, shift,
                count);
   endtask

   task automatic send_entry(logic [7:0] idx, logic [31:0] fa, logic [31:0] fb);
      send_item(OP_WRITE_ENTRY, 8'($urandom), idx, fa, fb, 3'($urandom), 19'($urandom));
   endtask

   // Stop offering, then wait until every code has arrived and the pipeline has drained.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_BIT_WIDTH) width_reg = value[3:0];
      else mask_reg = value;
   endtask

   // Fill the low 64 entries; masks and widths keep every code below 64 so each read is defined.
   task automatic test_fill_codebook();
      for (int i = 0; i < 64; i++) send_entry(8'(i), $urandom, $urandom);
   endtask

   // Conversion corner cases: zero, infinity, NaN, overflow, subnormals, ties.
   task automatic test_conversion();
      send_entry(8'd0, 32'h0000_0000, 32'h8000_0000);
      send_entry(8'd1, 32'h7F80_0000, 32'hFF80_0000);
      send_entry(8'd2, 32'h7FC1_2345, 32'hFF80_0001);
      send_entry(8'd3, 32'h477F_F000, 32'h4780_0000);
      send_entry(8'd4, 32'h3380_0000, 32'h3300_0001);
      send_entry(8'd5, 32'h3F80_1000, 32'h3F80_3000);
      send_entry(8'd6, 32'h3870_0000, 32'hB6FF_FFFF);
      send_entry(8'd7, 32'hFFFF_FFFF, 32'h3300_0000);
      write_reg(CSR_BIT_WIDTH, 8'd3);
      write_reg(CSR_CODE_MASK, 8'h07);
      send_start(3'd0, 19'd8);
      send_byte(8'b1000_1000);
      send_byte(8'b1100_0110);
      send_byte(8'b1111_1010);
   endtask

   // Width and mask extremes, offsets, short and empty tiles, stray bytes.
   task automatic test_directed_tiles();
      write_reg(CSR_BIT_WIDTH, 8'd1);
      write_reg(CSR_CODE_MASK, 8'hFF);
      send_start(3'd7, 19'd9);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h55);
      send_byte(8'hAA);
      write_reg(CSR_BIT_WIDTH, 8'd8);
      write_reg(CSR_CODE_MASK, 8'h00);
      send_start(3'd0, 19'd2);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_start(3'd0, 19'd0);
      send_byte(8'h12);
      send_item(OP_UNUSED, 8'($urandom), 8'($urandom), $urandom, $urandom, 3'($urandom),
                19'($urandom));
      write_reg(CSR_BIT_WIDTH, 8'd0);
      write_reg(CSR_CODE_MASK, 8'h3F);
      send_start(3'd4, 19'h7FFFF);
      send_byte(8'hF0);
      write_reg(CSR_BIT_WIDTH, 8'd15);
      send_start(3'd3, 19'd5);
      send_byte(8'hA5);
      send_byte(8'h3C);
      send_start(3'd1, 19'd1);
      send_byte(8'h7E);
   endtask

   // Random tiles under random settings, with long receiver hold-offs partway through.
   task automatic test_random_tiles();
      int sent;
      int len;
      sent = 0;
      while (sent < 180) begin
         if ($urandom_range(0, 3) == 0) begin
            write_reg(CSR_BIT_WIDTH, 8'($urandom_range(0, 15)));
            write_reg(CSR_CODE_MASK, 8'h3F & (($urandom_range(0, 2) == 0) ? 8'($urandom)
                      : 8'((1 << (width_reg == 0 ? 1 : width_reg > 8 ? 8 : width_reg)) - 1)));
         end
         if (sent > 100 && sent < 120) hold_cycles = 60;
         send_start(3'($urandom), ($urandom_range(0, 9) == 0) ? 19'($urandom)
                    : 19'($urandom_range(0, 20)));
         len = $urandom_range(1, 14);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 19))
               0: send_entry(8'($urandom), $urandom, $urandom);
               1: send_item(OP_UNUSED, 8'($urandom), 8'($urandom), $urandom, $urandom,
                            3'($urandom), 19'($urandom));
               default: send_byte(8'($urandom));
            endcase
         end
         sent += len + 1;
         if ($urandom_range(0, 7) == 0) drain();
      end
   endtask

   // Receiver: random stalls per transfer, plus long hold-offs on request.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         stall = $urandom_range(0, 3);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Compare each code transfer with the oldest expectation.
   always @(posedge clock) begin
      code_rec_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_codes.size() == 0) begin
            $display("%0t: unexpected code transfer, code %0h", $time, rsp_code_value);
            errors++;
         end else begin
            e = expected_codes.pop_front();
            if (e.code !== rsp_code_value) begin
               $display("%0t: code exp %0h got %0h", $time, e.code, rsp_code_value);
               errors++;
            end
            if (e.first_h !== rsp_first_half) begin
               $display("%0t: first half exp %0h got %0h", $time, e.first_h,
                        rsp_first_half);
               errors++;
            end
            if (e.second_h !== rsp_second_half) begin
               $display("%0t: second half exp %0h got %0h", $time, e.second_h,
                        rsp_second_half);
               errors++;
            end
            if (e.item_end !== rsp_last_of_item) begin
               $display("%0t: last of item exp %0b got %0b", $time, e.item_end,
                        rsp_last_of_item);
               errors++;
            end
            if (e.tile_end !== rsp_last_of_tile) begin
               $display("%0t: last of tile exp %0b got %0b", $time, e.tile_end,
                        rsp_last_of_tile);
               errors++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      for (int i = 0; i < 256; i++) begin
         book[i] = '0;
      end
      held_bits = '0;
      held_count = 0;
      skip_count = 0;
      codes_pending = 0;
      width_reg = 8;
      mask_reg = 8'hFF;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_codebook();
      test_conversion();
      test_directed_tiles();
      test_random_tiles();
      drain();
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
